// ===== src/bcc_pkg.sv =====
// Shared types and constants for the push-button click classifier.
package bcc_pkg;

	localparam int NUM_KEYS  = 4;
	localparam int PIN_BITS  = 4;
	localparam int KEY_IW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int PIN_EXT_W = (NUM_KEYS > PIN_BITS) ? NUM_KEYS : PIN_BITS;
	localparam int CNT_W     = 16;
	localparam int DIV_W     = 8;
	localparam int CFG_IW    = 2;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_DOWN     = 3'd1,
		PH_RELEASED = 3'd2,
		PH_DOUBLE   = 3'd3,
		PH_LONG     = 3'd4,
		PH_REPEAT   = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_SINGLE = 3'd1,
		EV_DOUBLE = 3'd2,
		EV_LONG   = 3'd3,
		EV_REPEAT = 3'd4
	} event_t;

	typedef enum logic {
		REQ_TICK = 1'b0,
		REQ_READ = 1'b1
	} req_t;

	typedef enum logic [CFG_IW-1:0] {
		REG_DOUBLE_WINDOW   = 2'd0,
		REG_LONG_HOLD       = 2'd1,
		REG_REPEAT_INTERVAL = 2'd2,
		REG_SAMPLE_PERIOD   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		phase_t             ph;
		event_t             ev;
		logic [CNT_W-1:0]   cnt;
	} key_state_t;

	localparam logic [CNT_W-1:0] DOUBLE_WINDOW_RST   = CNT_W'(200);
	localparam logic [CNT_W-1:0] LONG_HOLD_RST       = CNT_W'(1000);
	localparam logic [CNT_W-1:0] REPEAT_INTERVAL_RST = CNT_W'(200);
	localparam logic [DIV_W-1:0] SAMPLE_PERIOD_RST   = DIV_W'(20);

endpackage

// ===== src/button_click_classifier.sv =====
// Top level of the push-button click classifier: per-key machines and stream ports.
//
// Tells single, double, long and repeated presses apart on NUM_KEYS active-low
// push buttons, one small machine per key. A tick transaction (tuser = 0) carries
// the raw pin levels: it decrements every nonzero per-key countdown and advances a
// divider; every sample_period ticks it samples all pins (which also debounces them)
// and steps each key's machine, which may latch an event. A read transaction
// (tuser = 1) returns the named key's latched event and clears it. Every
// transaction yields exactly one result for the key named in key_number: its event
// and phase as they stand after a tick's update, or before a read's clear. A key
// number outside 1..NUM_KEYS returns bad_key = 1 with event and phase zero; a read
// of it clears nothing, while a tick still runs for every key. A sample period of
// zero samples on every tick. Keys beyond the pin vector always read as released.
// Rate: one transaction per clock cycle. All state updates in the cycle of
// acceptance; the result appears in the output register on the next cycle. The
// only stall source is the output register: input tready drops while a result
// waits there and the downstream side is not ready. Configuration writes take
// effect at the next edge and must be made while no transaction is in flight.
module button_click_classifier
	import bcc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// configuration write port
	input  logic                cfg_we,
	input  logic [CFG_IW-1:0]   cfg_index,
	input  logic [CNT_W-1:0]    cfg_data,
	// request stream
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [7:0]          s_axis_tdata,   // [3:0] pin_levels, [7:4] key_number
	input  logic                s_axis_tuser,   // [0] req_type
	// result stream
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [7:0]          m_axis_tdata,   // [2:0] event_code, [5:3] key_phase, [7:6] zero
	output logic                m_axis_tuser    // [0] bad_key
);

	// configuration registers
	logic [CNT_W-1:0] double_window_q;
	logic [CNT_W-1:0] long_hold_q;
	logic [CNT_W-1:0] repeat_interval_q;
	logic [DIV_W-1:0] sample_period_q;

	// per-key state and the sample divider
	key_state_t       key_q   [NUM_KEYS];
	key_state_t       key_upd [NUM_KEYS];
	key_state_t       key_nxt [NUM_KEYS];
	logic [DIV_W-1:0] div_q;
	logic [DIV_W-1:0] div_inc;
	logic [DIV_W-1:0] div_nxt;

	// decoded request
	logic                  in_accept;
	logic                  is_tick;
	logic                  is_read;
	logic [3:0]            key_number;
	logic [3:0]            pin_levels;
	logic [PIN_EXT_W-1:0]  pins_ext;
	logic                  sample;
	logic                  bad_key;
	logic [KEY_IW-1:0]     key_idx;

	// result register
	logic        out_valid_q;
	event_t      out_ev_q;
	phase_t      out_ph_q;
	logic        out_bad_q;

	assign in_accept  = s_axis_tvalid && s_axis_tready;
	assign is_tick    = (req_t'(s_axis_tuser) == REQ_TICK);
	assign is_read    = (req_t'(s_axis_tuser) == REQ_READ);
	assign pin_levels = s_axis_tdata[3:0];
	assign key_number = s_axis_tdata[7:4];

	// Pins beyond the physical vector read high, i.e. released.
	assign pins_ext = PIN_EXT_W'(pin_levels) | ~PIN_EXT_W'({PIN_BITS{1'b1}});

	assign bad_key = (key_number == 4'd0) || (32'(key_number) > NUM_KEYS);
	assign key_idx = KEY_IW'(key_number - 4'd1);

	// The divider wraps at its width; zero period compares true and samples every tick.
	assign div_inc = div_q + DIV_W'(1);
	assign sample  = (div_inc >= sample_period_q);
	assign div_nxt = is_tick ? (sample ? '0 : div_inc) : div_q;

	// Step one key's machine on a sample, with its countdown already decremented.
	function automatic key_state_t step_key(key_state_t s, logic down,
			logic [CNT_W-1:0] dwin, logic [CNT_W-1:0] lhold, logic [CNT_W-1:0] rint);
		key_state_t r;
		r = s;
		unique case (s.ph)
			PH_IDLE: begin
				if (down) begin
					r.cnt = lhold;
					r.ph  = PH_DOWN;
				end
			end
			PH_DOWN: begin
				if (!down) begin
					r.cnt = dwin;
					r.ph  = PH_RELEASED;
				end else if (s.cnt == '0) begin
					r.cnt = rint;
					r.ev  = EV_LONG;
					r.ph  = PH_LONG;
				end
			end
			PH_RELEASED: begin
				if (down) begin
					r.ev = EV_DOUBLE;
					r.ph = PH_DOUBLE;
				end else if (s.cnt == '0) begin
					r.ev = EV_SINGLE;
					r.ph = PH_IDLE;
				end
			end
			PH_DOUBLE: begin
				if (!down)
					r.ph = PH_IDLE;
			end
			PH_LONG, PH_REPEAT: begin
				if (!down) begin
					r.ph = PH_IDLE;
				end else if (s.cnt == '0) begin
					r.cnt = rint;
					r.ev  = EV_REPEAT;
					r.ph  = PH_REPEAT;
				end
			end
			default: r.ph = PH_IDLE;
		endcase
		return r;
	endfunction

	// Apply the tick: decrement, then step every key on a sample.
	always_comb begin
		key_state_t tmp;
		for (int k = 0; k < NUM_KEYS; k++) begin
			tmp = key_q[k];
			if (is_tick) begin
				if (tmp.cnt != '0)
					tmp.cnt = tmp.cnt - CNT_W'(1);
				if (sample)
					tmp = step_key(tmp, ~pins_ext[k], double_window_q, long_hold_q,
						repeat_interval_q);
			end
			key_upd[k] = tmp;
		end
	end

	// Clear the named key's latched event on a good read.
	always_comb begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			key_nxt[k] = key_upd[k];
			if (is_read && !bad_key && (key_idx == KEY_IW'(k)))
				key_nxt[k].ev = EV_NONE;
		end
	end

	assign s_axis_tready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			double_window_q   <= DOUBLE_WINDOW_RST;
			long_hold_q       <= LONG_HOLD_RST;
			repeat_interval_q <= REPEAT_INTERVAL_RST;
			sample_period_q   <= SAMPLE_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DOUBLE_WINDOW:   double_window_q   <= cfg_data;
				REG_LONG_HOLD:       long_hold_q       <= cfg_data;
				REG_REPEAT_INTERVAL: repeat_interval_q <= cfg_data;
				REG_SAMPLE_PERIOD:   sample_period_q   <= cfg_data[DIV_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance key state and divider on each accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KEYS; k++)
				key_q[k] <= '{ph: PH_IDLE, ev: EV_NONE, cnt: '0};
			div_q <= '0;
		end else if (in_accept) begin
			for (int k = 0; k < NUM_KEYS; k++)
				key_q[k] <= key_nxt[k];
			div_q <= div_nxt;
		end
	end

	// Hold the result until taken; load a new one on every accept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			out_bad_q <= bad_key;
			out_ev_q  <= bad_key ? EV_NONE : key_upd[key_idx].ev;
			out_ph_q  <= bad_key ? PH_IDLE : key_upd[key_idx].ph;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_ph_q, out_ev_q};
	assign m_axis_tuser  = out_bad_q;

	// A bad key reports nothing but the flag.
	a_bad_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[5:0] == 6'd0)
		else $error("bad key result carries event or phase");

	// Every accepted transaction leaves a result in the output register.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> m_axis_tvalid)
		else $error("accepted transaction produced no result");

	// A good read leaves the key's event cleared.
	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && is_read && !bad_key |=> key_q[$past(key_idx)].ev == EV_NONE)
		else $error("read did not clear latched event");

	// The divider moves only on an accepted tick.
	a_div_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_accept && is_tick) |=> $stable(div_q))
		else $error("divider moved without a tick");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking stream testbench for the push-button click classifier.
`timescale 1ns / 100ps

module tb_top;
	import bcc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int IDLE_PCT    = 28;

	typedef struct packed {
		req_t       req;
		logic [3:0] pins;
		logic [3:0] key;
	} key_request_t;

	typedef struct packed {
		event_t ev;
		phase_t ph;
		logic   bad;
	} key_report_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CNT_W-1:0] cfg_data = '0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [7:0]       s_axis_tdata = '0;   // [3:0] pin_levels, [7:4] key_number
	logic             s_axis_tuser = 1'b0; // [0] req_type
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [7:0]       m_axis_tdata;        // [2:0] event_code, [5:3] key_phase, [7:6] zero
	logic             m_axis_tuser;        // [0] bad_key

	// Stimulus and scoreboard storage
	key_request_t pending_reqs[$];
	key_report_t  expected_reports[$];
	key_request_t next_req;
	key_report_t  want;
	int           mismatch_count = 0;
	int           stall_cycles = 0;
	bit           no_idle = 1'b0;
	bit           sender_hold = 1'b0;
	logic [3:0]   live_pins = 4'hF;

	// Shadow copy of the per-key machines and the configuration
	phase_t           shadow_phase[NUM_KEYS];
	event_t           shadow_event[NUM_KEYS];
	logic [CNT_W-1:0] shadow_count[NUM_KEYS];
	logic [DIV_W-1:0] shadow_div;
	logic [CNT_W-1:0] cfg_dwin, cfg_lhold, cfg_rpt;
	logic [DIV_W-1:0] cfg_sample;

	button_click_classifier u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #2 clk = ~clk;

	// Advance the shadow machines by one accepted request and queue the report it yields.
	task automatic classify_request(input req_t req, input logic [3:0] pins,
			input logic [3:0] key);
		key_report_t rep;
		logic        down;
		int          k;
		if (req == REQ_TICK) begin
			for (k = 0; k < NUM_KEYS; k++)
				if (shadow_count[k] != '0)
					shadow_count[k] = shadow_count[k] - 1'b1;
			shadow_div = shadow_div + 1'b1;
			// a zero period compares true on every tick, so it acts like 1
			if (shadow_div >= cfg_sample) begin
				shadow_div = '0;
				for (k = 0; k < NUM_KEYS; k++) begin
					// keys beyond the pin vector always read as released
					down = (k < PIN_BITS) ? !pins[k] : 1'b0;
					case (shadow_phase[k])
						PH_IDLE: begin
							if (down) begin
								shadow_count[k] = cfg_lhold;
								shadow_phase[k] = PH_DOWN;
							end
						end
						PH_DOWN: begin
							if (!down) begin
								shadow_count[k] = cfg_dwin;
								shadow_phase[k] = PH_RELEASED;
							end else if (shadow_count[k] == '0) begin
								shadow_count[k] = cfg_rpt;
								shadow_event[k] = EV_LONG;
								shadow_phase[k] = PH_LONG;
							end
						end
						PH_RELEASED: begin
							if (down) begin
								shadow_event[k] = EV_DOUBLE;
								shadow_phase[k] = PH_DOUBLE;
							end else if (shadow_count[k] == '0) begin
								shadow_event[k] = EV_SINGLE;
								shadow_phase[k] = PH_IDLE;
							end
						end
						PH_DOUBLE: begin
							if (!down)
								shadow_phase[k] = PH_IDLE;
						end
						PH_LONG, PH_REPEAT: begin
							if (!down) begin
								shadow_phase[k] = PH_IDLE;
							end else if (shadow_count[k] == '0) begin
								shadow_count[k] = cfg_rpt;
								shadow_event[k] = EV_REPEAT;
								shadow_phase[k] = PH_REPEAT;
							end
						end
						default: shadow_phase[k] = PH_IDLE;
					endcase
				end
			end
		end
		// a bad key reports zeros and clears nothing
		rep.ev  = EV_NONE;
		rep.ph  = PH_IDLE;
		rep.bad = 1'b1;
		if (key >= 1 && key <= NUM_KEYS) begin
			rep.ev  = shadow_event[key - 1];
			rep.ph  = shadow_phase[key - 1];
			rep.bad = 1'b0;
			if (req == REQ_READ)
				shadow_event[key - 1] = EV_NONE;
		end
		expected_reports.push_back(rep);
	endtask

	task automatic push_req(input req_t req, input logic [3:0] pins, input logic [3:0] key);
		key_request_t r;
		r.req  = req;
		r.pins = pins;
		r.key  = key;
		pending_reqs.push_back(r);
	endtask

	// Hold until the sender is empty and every report has come back.
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_reqs.size() != 0 || s_axis_tvalid || expected_reports.size() != 0);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CNT_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_DOUBLE_WINDOW:   cfg_dwin   = val;
			REG_LONG_HOLD:       cfg_lhold  = val;
			REG_REPEAT_INTERVAL: cfg_rpt    = val;
			REG_SAMPLE_PERIOD:   cfg_sample = val[DIV_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_timing(input logic [CNT_W-1:0] dwin, input logic [CNT_W-1:0] lhold,
			input logic [CNT_W-1:0] rpt, input logic [CNT_W-1:0] sample);
		write_reg(REG_DOUBLE_WINDOW, dwin);
		write_reg(REG_LONG_HOLD, lhold);
		write_reg(REG_REPEAT_INTERVAL, rpt);
		write_reg(REG_SAMPLE_PERIOD, sample);
	endtask

	// Queue press/release traffic: pins mostly follow a slowly changing level per key,
	// with reads, glitch ticks and bad key numbers mixed in.
	task automatic queue_presses(input int n, input int flip_pct);
		int          i;
		int          roll;
		logic [3:0]  key;
		for (i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			key  = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(4, 1));
			if (roll < 20) begin
				push_req(REQ_READ, 4'($urandom_range(15)), key);
			end else if (roll < 25) begin
				push_req(REQ_TICK, 4'($urandom_range(15)), key);
			end else begin
				if ($urandom_range(99) < flip_pct)
					live_pins[$urandom_range(3)] ^= 1'b1;
				push_req(REQ_TICK, live_pins, key);
			end
		end
	endtask

	// Driver: predict on acceptance, then load the next request unless idling.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				classify_request(req_t'(s_axis_tuser), s_axis_tdata[3:0], s_axis_tdata[7:4]);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_reqs.size() != 0 && !sender_hold &&
						(no_idle || $urandom_range(99) >= IDLE_PCT)) begin
					next_req = pending_reqs.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {next_req.key, next_req.pins};
					s_axis_tuser  <= next_req.req;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each report transaction with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_reports.size() == 0) begin
				$display("%0t: unexpected report: actual tdata %h tuser %b",
					$time, m_axis_tdata, m_axis_tuser);
				mismatch_count++;
			end else begin
				want = expected_reports.pop_front();
				if (m_axis_tdata[2:0] !== want.ev) begin
					$display("%0t: event_code mismatch: expected %0d, actual %0d",
						$time, want.ev, m_axis_tdata[2:0]);
					mismatch_count++;
				end
				if (m_axis_tdata[5:3] !== want.ph) begin
					$display("%0t: key_phase mismatch: expected %0d, actual %0d",
						$time, want.ph, m_axis_tdata[5:3]);
					mismatch_count++;
				end
				if (m_axis_tuser !== want.bad) begin
					$display("%0t: bad_key mismatch: expected %0d, actual %0d",
						$time, want.bad, m_axis_tuser);
					mismatch_count++;
				end
			end
		end
		m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
	end

	// Watchdog: end the run when no transaction moves for too long.
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_axis_tvalid && s_axis_tready) ||
				(m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			shadow_phase[k] = PH_IDLE;
			shadow_event[k] = EV_NONE;
			shadow_count[k] = '0;
		end
		shadow_div = '0;
		cfg_dwin   = DOUBLE_WINDOW_RST;
		cfg_lhold  = LONG_HOLD_RST;
		cfg_rpt    = REPEAT_INTERVAL_RST;
		cfg_sample = SAMPLE_PERIOD_RST;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: bad keys at reset timing, then each click kind on a fast setup
		push_req(REQ_READ, 4'hF, 4'd0);
		push_req(REQ_TICK, 4'hA, 4'd15);
		wait_idle();
		set_timing(16'd2, 16'd3, 16'd1, 16'd1);
		push_req(REQ_TICK, 4'h0, 4'd5);     // every key pressed at once
		push_req(REQ_TICK, 4'hF, 4'd1);     // all released
		push_req(REQ_TICK, 4'hF, 4'd2);
		push_req(REQ_TICK, 4'hF, 4'd3);
		push_req(REQ_TICK, 4'hF, 4'd4);     // release window runs out: single
		push_req(REQ_READ, 4'hF, 4'd1);
		push_req(REQ_READ, 4'hF, 4'd1);     // cleared by the previous read
		push_req(REQ_TICK, 4'hD, 4'd2);     // key 2: press, release, press
		push_req(REQ_TICK, 4'hF, 4'd2);
		push_req(REQ_TICK, 4'hD, 4'd2);
		push_req(REQ_TICK, 4'hF, 4'd2);
		push_req(REQ_READ, 4'hF, 4'd2);
		for (int i = 0; i < 5; i++)         // key 4 held: long, then repeats
			push_req(REQ_TICK, 4'h7, 4'd4);
		push_req(REQ_READ, 4'h7, 4'd4);
		push_req(REQ_TICK, 4'h7, 4'd4);
		push_req(REQ_TICK, 4'h7, 4'd4);
		push_req(REQ_READ, 4'h7, 4'd4);
		push_req(REQ_TICK, 4'hF, 4'd4);
		wait_idle();

		// Sample every tick with short windows: lots of clicks and doubles
		set_timing(16'd3, 16'd6, 16'd2, 16'd1);
		queue_presses(150, 40);
		wait_idle();

		// All intervals zero, sample period zero
		set_timing(16'd0, 16'd0, 16'd0, 16'd0);
		queue_presses(90, 30);
		wait_idle();

		// Largest values: the divider climbs well past the next period
		set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd255);
		queue_presses(60, 20);
		wait_idle();

		// Lower the period below the divider, hold the sender once until drained,
		// then run the rest with both sides always ready
		set_timing(16'd5, 16'd10, 16'd3, 16'd3);
		queue_presses(200, 12);
		do @(negedge clk);
		while (pending_reqs.size() > 100);
		sender_hold = 1'b1;
		do @(negedge clk);
		while (s_axis_tvalid || expected_reports.size() != 0);
		sender_hold = 1'b0;
		no_idle = 1'b1;
		wait_idle();
		no_idle = 1'b0;

		// Random short timing
		set_timing(16'($urandom_range(12)), 16'($urandom_range(20)),
			16'($urandom_range(6)), 16'($urandom_range(4, 1)));
		queue_presses(130, 25);
		wait_idle();

		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && expected_reports.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
